// ----- rtl/tmr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick timer package
// Shared constants, codes and the bank write command for the tick timer.
// ----------------------------------------------------------------------------
package tmr_pkg;

  localparam int CHANNELS = 12;
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MASK_W   = 12;
  localparam int TIME_W   = 32;
  localparam int CHK_W    = 7;

  localparam logic [2:0] OP_TICK         = 3'd0;
  localparam logic [2:0] OP_SET          = 3'd1;
  localparam logic [2:0] OP_CANCEL_NOW   = 3'd2;
  localparam logic [2:0] OP_CANCEL_AFTER = 3'd3;
  localparam logic [2:0] OP_CLEAR_ALL    = 3'd4;

  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_INVALID       = 2'd1;
  localparam logic [1:0] ST_NOT_ARMED     = 2'd2;
  localparam logic [1:0] ST_ZERO_INTERVAL = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic              arm;
    logic              disarm;
    logic              clear_all;
    logic              set_mode;
    logic              mode;
    logic              wr_deadline;
    logic              wr_interval;
    idx_t              idx;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] interval;
  } bank_cmd_t;

  function automatic idx_t to_idx(input logic [3:0] id);
    return IDX_W'(id);
  endfunction

endpackage

// ----- rtl/multi_channel_tick_timer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-channel tick timer
// Bank of timer channels with set, cancel, clear-all and tick requests.
// ----------------------------------------------------------------------------
// A tick request walks the channels one per cycle through a single shared
// adder and comparator: each channel is scanned in turn, then the time
// advances, then the result register is loaded once it is free. Set, cancel,
// clear-all and invalid requests pass through the execute state before the
// result is loaded. The block is ready again the cycle after the result is
// loaded. One request is in work at a time; a new request is accepted while
// the previous result still waits in the output register.
module multi_channel_tick_timer_top
  import tmr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        operation,
  input  logic [3:0]        channel,
  input  logic [TIME_W-1:0] interval,
  input  logic              single_use,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MASK_W-1:0] fired_mask,
  output logic [1:0]        status
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_TIME = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]          state, state_next;
  logic [2:0]          op_reg;
  logic [3:0]          id_reg;
  logic [TIME_W-1:0]   ivl_reg;
  logic                one_reg;
  idx_t                scan_idx;
  logic [TIME_W-1:0]   current_time;
  logic [MASK_W-1:0]   fired_acc;
  logic [1:0]          st_reg, st_next;

  bank_cmd_t           cmd;
  idx_t                rd_idx;
  logic [TIME_W-1:0]   rd_deadline, rd_interval;
  logic [CHANNELS-1:0] armed, one_shot;
  logic [TIME_W-1:0]   alu_b, alu_sum;
  logic                alu_equal;
  logic                id_bad, scan_last, hit;

  tmr_bank u_bank (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rd_idx      (rd_idx),
    .rd_deadline (rd_deadline),
    .rd_interval (rd_interval),
    .armed       (armed),
    .one_shot    (one_shot)
  );

  tmr_alu u_alu (
    .a     (current_time),
    .b     (alu_b),
    .c     (rd_deadline),
    .sum   (alu_sum),
    .equal (alu_equal)
  );

  assign in_ready  = (state == S_IDLE);
  assign id_bad    = (CHK_W'(id_reg) >= CHK_W'(CHANNELS));
  assign scan_last = (scan_idx == IDX_W'(CHANNELS - 1));
  assign rd_idx    = (state == S_SCAN) ? scan_idx : to_idx(id_reg);
  assign hit       = armed[rd_idx] && alu_equal;

  always_comb begin
    case (state)
      S_SCAN:  alu_b = rd_interval;
      S_TIME:  alu_b = TIME_W'(1);
      default: alu_b = ivl_reg;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.idx      = rd_idx;
    cmd.deadline = alu_sum;
    cmd.interval = ivl_reg;
    cmd.mode     = one_reg;
    st_next      = ST_OK;
    state_next   = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (operation == OP_TICK) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (op_reg)
          OP_SET: begin
            if (id_bad) begin
              st_next = ST_INVALID;
            end else if (ivl_reg == '0) begin
              st_next = ST_ZERO_INTERVAL;
            end else begin
              cmd.wr_interval = 1'b1;
              cmd.wr_deadline = 1'b1;
              cmd.set_mode    = 1'b1;
              cmd.arm         = 1'b1;
            end
          end
          OP_CANCEL_NOW: begin
            if (id_bad) begin
              st_next = ST_INVALID;
            end else if (!armed[rd_idx]) begin
              st_next = ST_NOT_ARMED;
            end else begin
              cmd.disarm = 1'b1;
            end
          end
          OP_CANCEL_AFTER: begin
            if (id_bad) begin
              st_next = ST_INVALID;
            end else begin
              cmd.set_mode = 1'b1;
              cmd.mode     = 1'b1;
            end
          end
          OP_CLEAR_ALL: begin
            cmd.clear_all = 1'b1;
          end
          default: begin
            st_next = ST_INVALID;
          end
        endcase
      end
      S_SCAN: begin
        // A fired periodic channel re-arms at now plus its interval.
        if (hit) begin
          cmd.disarm      = one_shot[rd_idx];
          cmd.wr_deadline = !one_shot[rd_idx];
        end
        if (scan_last) begin
          state_next = S_TIME;
        end
      end
      S_TIME: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      current_time <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EXEC && op_reg == OP_CLEAR_ALL) begin
        current_time <= '0;
      end else if (state == S_TIME) begin
        current_time <= alu_sum;
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_reg    <= operation;
      id_reg    <= channel;
      ivl_reg   <= interval;
      one_reg   <= single_use;
      scan_idx  <= '0;
      fired_acc <= '0;
      st_reg    <= ST_OK;
    end else if (state == S_EXEC) begin
      st_reg <= st_next;
    end else if (state == S_SCAN) begin
      if (!scan_last) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      // Channels beyond the mask width shift out and are not reported.
      if (hit) begin
        fired_acc <= fired_acc | (MASK_W'(1) << scan_idx);
      end
    end
    if (state == S_DONE && (!out_valid || out_ready)) begin
      fired_mask <= fired_acc;
      status     <= st_reg;
    end
  end

`ifndef SYNTHESIS
  a_fired_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fired_mask != '0) |-> (status == ST_OK))
    else $error("fired channels reported with a non-ok status");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_idx <= IDX_W'(CHANNELS - 1)))
    else $error("channel scan index out of range");

  a_clear_zeroes_time: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && op_reg == OP_CLEAR_ALL) |=> (current_time == '0 && armed == '0))
    else $error("clear-all left time or armed channels");

  a_one_shot_disarms: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && hit && one_shot[scan_idx]) |=> !armed[$past(scan_idx)])
    else $error("fired one-shot channel still armed");

  a_time_advances: assert property (@(posedge clk) disable iff (rst)
    (state == S_TIME) |=> (current_time == $past(current_time) + TIME_W'(1)))
    else $error("time did not advance after a tick scan");
`endif

endmodule

// ----- rtl/tmr_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick timer arithmetic unit
// The one adder and equality comparator shared by the set, scan and time steps.
// ----------------------------------------------------------------------------
module tmr_alu
  import tmr_pkg::*;
(
  input  logic [TIME_W-1:0] a,
  input  logic [TIME_W-1:0] b,
  input  logic [TIME_W-1:0] c,
  output logic [TIME_W-1:0] sum,
  output logic              equal
);

  // The sum wraps modulo 2^32, which is what deadlines need.
  assign sum   = a + b;
  assign equal = (a == c);

endmodule

// ----- rtl/tmr_bank.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick timer channel bank
// Per-channel deadline, interval, armed and mode state with one write command
// and one read index per cycle.
// ----------------------------------------------------------------------------
module tmr_bank
  import tmr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  bank_cmd_t           cmd,
  input  idx_t                rd_idx,
  output logic [TIME_W-1:0]   rd_deadline,
  output logic [TIME_W-1:0]   rd_interval,
  output logic [CHANNELS-1:0] armed,
  output logic [CHANNELS-1:0] one_shot
);

  logic [TIME_W-1:0] deadline [CHANNELS];
  logic [TIME_W-1:0] interval [CHANNELS];

  // Deadline and interval are only read for armed channels, and arming
  // always writes both, so they need no reset.
  always_ff @(posedge clk) begin
    if (cmd.wr_deadline) begin
      deadline[cmd.idx] <= cmd.deadline;
    end
    if (cmd.wr_interval) begin
      interval[cmd.idx] <= cmd.interval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed    <= '0;
      one_shot <= '1;
    end else begin
      if (cmd.clear_all) begin
        armed <= '0;
      end else if (cmd.arm) begin
        armed[cmd.idx] <= 1'b1;
      end else if (cmd.disarm) begin
        armed[cmd.idx] <= 1'b0;
      end
      if (cmd.set_mode) begin
        one_shot[cmd.idx] <= cmd.mode;
      end
    end
  end

  assign rd_deadline = deadline[rd_idx];
  assign rd_interval = interval[rd_idx];

endmodule

// ----- sim/tb_multi_channel_tick_timer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-channel tick timer testbench
// Sends set, cancel, clear-all, tick and invalid requests through the request
// handshake. A behavioral copy of the channel bank predicts each fired mask
// and status. A short directed table comes first, then a long randomized
// stream. Both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb_multi_channel_tick_timer_top;
  import tmr_pkg::*;

  // Operation codes that the block must reject.
  localparam logic [2:0] OP_RSVD_5 = 3'd5;
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  localparam int RANDOM_REQUESTS = 1950;
  localparam int DIR_ROWS        = 27;

  typedef struct packed {
    logic [2:0]        op;
    logic [3:0]        id;
    logic [TIME_W-1:0] ivl;
    logic              one;
    logic              typed;
    logic [MASK_W-1:0] mask;
    logic [1:0]        st;
  } timer_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        operation = OP_TICK;
  logic [3:0]        channel = 4'd0;
  logic [TIME_W-1:0] interval = '0;
  logic              single_use = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [MASK_W-1:0] fired_mask;
  logic [1:0]        status;

  // Behavioral copy of the channel bank.
  logic [TIME_W-1:0] now_ticks;
  logic [TIME_W-1:0] due_at [CHANNELS];
  logic [TIME_W-1:0] period_len [CHANNELS];
  logic              armed [CHANNELS];
  logic              one_shot [CHANNELS];

  logic [MASK_W-1:0] pending_mask [$];
  logic [1:0]        pending_status [$];
  int                mismatches = 0;
  int                burst_left = 0;
  logic [15:0]       rx_cycle = '0;
  timer_row_t        plan [DIR_ROWS];

  multi_channel_tick_timer_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .channel    (channel),
    .interval   (interval),
    .single_use (single_use),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .fired_mask (fired_mask),
    .status     (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic timer_row_t step_row(input logic [2:0] op, input logic [3:0] id,
                                          input logic [TIME_W-1:0] ivl, input logic one,
                                          input logic typed, input logic [MASK_W-1:0] mask,
                                          input logic [1:0] st);
    timer_row_t r;
    r.op    = op;
    r.id    = id;
    r.ivl   = ivl;
    r.one   = one;
    r.typed = typed;
    r.mask  = mask;
    r.st    = st;
    return r;
  endfunction

  function automatic void predict_timer(input logic [2:0] op, input logic [3:0] id,
                                        input logic [TIME_W-1:0] ivl, input logic one,
                                        output logic [MASK_W-1:0] mask,
                                        output logic [1:0] st);
    mask = '0;
    st   = ST_OK;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (armed[i] && due_at[i] == now_ticks) begin
            if (i < MASK_W) mask[i] = 1'b1;
            if (one_shot[i]) armed[i] = 1'b0;
            else due_at[i] = now_ticks + period_len[i];
          end
        end
        now_ticks = now_ticks + 1'b1;
      end
      OP_SET: begin
        if (int'(id) >= CHANNELS) begin
          st = ST_INVALID;
        end else if (ivl == '0) begin
          st = ST_ZERO_INTERVAL;
        end else begin
          period_len[id] = ivl;
          one_shot[id]   = one;
          due_at[id]     = now_ticks + ivl;
          armed[id]      = 1'b1;
        end
      end
      OP_CANCEL_NOW: begin
        if (int'(id) >= CHANNELS) st = ST_INVALID;
        else if (!armed[id]) st = ST_NOT_ARMED;
        else armed[id] = 1'b0;
      end
      OP_CANCEL_AFTER: begin
        if (int'(id) >= CHANNELS) st = ST_INVALID;
        else one_shot[id] = 1'b1;
      end
      OP_CLEAR_ALL: begin
        for (int i = 0; i < CHANNELS; i++) armed[i] = 1'b0;
        now_ticks = '0;
      end
      default: begin
        st = ST_INVALID;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Presents one request, holds it until accepted, then records its expected result.
  task automatic drive_request(input timer_row_t rq);
    logic [MASK_W-1:0] want_mask;
    logic [1:0]        want_st;
    int                gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    operation  = rq.op;
    channel    = rq.id;
    interval   = rq.ivl;
    single_use = rq.one;
    in_valid   = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_timer(rq.op, rq.id, rq.ivl, rq.one, want_mask, want_st);
    if (rq.typed) begin
      want_mask = rq.mask;
      want_st   = rq.st;
    end
    pending_mask.push_back(want_mask);
    pending_status.push_back(want_st);
    @(negedge clk);
  endtask

  // The receiver cycles through steady, patterned, random and long-stall phases.
  always @(negedge clk) begin
    rx_cycle = rx_cycle + 1'b1;
    case (rx_cycle[9:8])
      2'd0: out_ready = 1'b1;
      2'd1: out_ready = (rx_cycle[1:0] != 2'b11);
      2'd2: out_ready = ($urandom_range(3) != 0);
      default: out_ready = (rx_cycle[4:0] > 5'd19);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_mask.size() == 0) begin
        report_mismatch("unexpected result, status", status, 0);
      end else begin
        if (fired_mask !== pending_mask[0])
          report_mismatch("fired_mask", fired_mask, pending_mask[0]);
        if (status !== pending_status[0])
          report_mismatch("status", status, pending_status[0]);
        void'(pending_mask.pop_front());
        void'(pending_status.pop_front());
      end
    end
  end

  initial begin
    timer_row_t rnd;
    int         pick;
    logic [2:0] op;
    logic [3:0] id;
    logic [TIME_W-1:0] ivl;

    now_ticks = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      due_at[i]     = '0;
      period_len[i] = '0;
      armed[i]      = 1'b0;
      one_shot[i]   = 1'b1;
    end

    plan = '{
      step_row(OP_TICK,         4'd0,  32'd0,        1'b0, 1'b1, 12'h000, ST_OK),
      step_row(OP_RSVD_5,       4'd0,  32'd0,        1'b0, 1'b1, 12'h000, ST_INVALID),
      step_row(OP_RSVD_7,       4'd15, 32'hFFFFFFFF, 1'b1, 1'b1, 12'h000, ST_INVALID),
      step_row(OP_SET,          4'd12, 32'd5,        1'b0, 1'b1, 12'h000, ST_INVALID),
      step_row(OP_SET,          4'd15, 32'hFFFFFFFF, 1'b1, 1'b1, 12'h000, ST_INVALID),
      step_row(OP_SET,          4'd0,  32'd0,        1'b1, 1'b1, 12'h000, ST_ZERO_INTERVAL),
      step_row(OP_CANCEL_NOW,   4'd3,  32'd0,        1'b0, 1'b1, 12'h000, ST_NOT_ARMED),
      step_row(OP_CANCEL_NOW,   4'd15, 32'd0,        1'b0, 1'b1, 12'h000, ST_INVALID),
      step_row(OP_CANCEL_AFTER, 4'd14, 32'd0,        1'b0, 1'b1, 12'h000, ST_INVALID),
      step_row(OP_CANCEL_AFTER, 4'd5,  32'd0,        1'b0, 1'b1, 12'h000, ST_OK),
      step_row(OP_SET,          4'd0,  32'd1,        1'b1, 1'b1, 12'h000, ST_OK),
      step_row(OP_SET,          4'd11, 32'd2,        1'b0, 1'b1, 12'h000, ST_OK),
      // Deadline wraps past the top of the time range.
      step_row(OP_SET,          4'd7,  32'hFFFFFFFF, 1'b0, 1'b1, 12'h000, ST_OK),
      step_row(OP_TICK,         4'd0,  32'd0,        1'b0, 1'b0, 12'h000, ST_OK),
      step_row(OP_TICK,         4'd8,  32'd0,        1'b1, 1'b0, 12'h000, ST_OK),
      step_row(OP_TICK,         4'd0,  32'd0,        1'b0, 1'b0, 12'h000, ST_OK),
      step_row(OP_CANCEL_AFTER, 4'd11, 32'd0,        1'b0, 1'b0, 12'h000, ST_OK),
      step_row(OP_TICK,         4'd0,  32'd0,        1'b0, 1'b0, 12'h000, ST_OK),
      step_row(OP_TICK,         4'd0,  32'd0,        1'b0, 1'b0, 12'h000, ST_OK),
      step_row(OP_CANCEL_NOW,   4'd11, 32'd0,        1'b0, 1'b0, 12'h000, ST_OK),
      step_row(OP_CANCEL_NOW,   4'd7,  32'd0,        1'b0, 1'b0, 12'h000, ST_OK),
      step_row(OP_SET,          4'd3,  32'd1,        1'b0, 1'b0, 12'h000, ST_OK),
      step_row(OP_TICK,         4'd0,  32'd0,        1'b0, 1'b0, 12'h000, ST_OK),
      step_row(OP_TICK,         4'd0,  32'd0,        1'b0, 1'b0, 12'h000, ST_OK),
      step_row(OP_RSVD_6,       4'd9,  32'h80000000, 1'b1, 1'b1, 12'h000, ST_INVALID),
      step_row(OP_CLEAR_ALL,    4'd0,  32'd0,        1'b0, 1'b1, 12'h000, ST_OK),
      // Nothing is armed after clear-all.
      step_row(OP_TICK,         4'd0,  32'd0,        1'b0, 1'b1, 12'h000, ST_OK)
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[k]) drive_request(plan[k]);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(99);
      id   = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                      : 4'($urandom_range(CHANNELS - 1));
      ivl  = $urandom;
      if (pick < 42) begin
        op = OP_TICK;
      end else if (pick < 70) begin
        op = OP_SET;
        // Mostly short intervals so channels fire often; some zero or huge.
        case ($urandom_range(19))
          0: ivl = '0;
          1: ivl = $urandom;
          2: ivl = 32'hFFFFFFFF - $urandom_range(3);
          default: ivl = $urandom_range(1, 24);
        endcase
      end else if (pick < 80) begin
        op = OP_CANCEL_NOW;
      end else if (pick < 88) begin
        op = OP_CANCEL_AFTER;
      end else if (pick < 91) begin
        op = OP_CLEAR_ALL;
      end else if (pick < 96) begin
        op = 3'($urandom_range(OP_RSVD_5, OP_RSVD_7));
      end else begin
        op = 3'($urandom_range(7));
      end
      rnd = step_row(op, id, ivl, 1'($urandom_range(1)), 1'b0, '0, ST_OK);
      drive_request(rnd);
    end
    in_valid = 1'b0;

    while (pending_mask.size() != 0) @(posedge clk);
    repeat (CHANNELS + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
